// ===== hw/rtl/copm_pkg.sv =====
// copm_pkg: shared types and constants for the cursor outline/premultiply block.
// Used by copm_cell, copm_outbuf and cursor_outline_premultiply.
package copm_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CFG_DW    = 11;
  localparam int unsigned CFG_IW    = 2;
  localparam int unsigned WIDTH_RST = 32;
  localparam int unsigned HEIGHT_RST = 32;

  localparam logic [CFG_IW-1:0] CFG_WIDTH   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_OUTLINE = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hff00_0000;
  localparam logic [PIX_W-1:0] OPAQUE_WHITE = 32'hffff_ffff;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
    logic tail;
  } cell_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

endpackage

// ===== hw/rtl/copm_cell.sv =====
// copm_cell: one stage of the pending-pixel window and the above-row flag line.
// Depends on copm_pkg.
module copm_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  copm_pkg::cell_ctrl_t     ctrl,
  input  logic [copm_pkg::PIX_W-1:0] in_pix,
  input  logic                     new_flag,
  input  logic [copm_pkg::PIX_W-1:0] nbr_pix,
  input  logic                     nbr_flag,
  output logic [copm_pkg::PIX_W-1:0] pix,
  output logic                     flag
);
  import copm_pkg::*;

  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             flag_r, flag_nxt;

  always_comb begin
    if (ctrl.load) begin
      pix_nxt = in_pix;
    end else if (ctrl.shift) begin
      pix_nxt = nbr_pix;
    end else begin
      pix_nxt = pix_r;
    end

    if (ctrl.clear) begin
      flag_nxt = 1'b0;
    end else if (ctrl.shift) begin
      flag_nxt = ctrl.tail ? new_flag : nbr_flag;
    end else begin
      flag_nxt = flag_r;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  assign pix  = pix_r;
  assign flag = flag_r;

endmodule

// ===== hw/rtl/copm_outbuf.sv =====
// copm_outbuf: output register plus one skid stage for the result channel.
// Depends on copm_pkg.
module copm_outbuf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       res_valid,
  input  copm_pkg::res_t             res,
  output logic                       up_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [copm_pkg::PIX_W-1:0] out_pixel,
  output logic                       out_last
);
  import copm_pkg::*;

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_d_r, out_d_nxt;
  res_t skid_d_r, skid_d_nxt;
  logic take;

  always_comb begin
    take       = !out_v_r || !out_stall;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (take) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = res_valid;
        out_d_nxt = res;
      end
    end else if (res_valid) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign up_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_pixel = out_d_r.pixel;
  assign out_last  = out_d_r.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while output register is empty");

endmodule

// ===== hw/rtl/cursor_outline_premultiply.sv =====
// cursor_outline_premultiply: four-neighbor outline and alpha premultiply, top level.
// Depends on copm_pkg, copm_cell, copm_outbuf.
//
//   channel | ports                                   | beat
//   in      | in_valid, in_stall, in_req_type, in_pixel_in | pixel or drain item
//   out     | out_valid, out_stall, out_pixel_out, out_last_pixel | one result pixel
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata          | register write
//
// One input beat per cycle while in_stall is low; a result goes into the output register,
// or into the skid stage behind a stalled output, on the beat that releases it. Pixels
// are held in a chain of MAX_WIDTH cells, so a pixel is released by the beat one row
// after it, or by a drain beat. Reset is synchronous; no clearing pass. in_stall rises
// only while the skid stage holds a beat behind a stalled output register.
module cursor_outline_premultiply #(
  parameter int unsigned MAX_WIDTH  = copm_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = copm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [copm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [copm_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [copm_pkg::PIX_W-1:0]  in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [copm_pkg::PIX_W-1:0]  out_pixel_out,
  output logic                        out_last_pixel
);
  import copm_pkg::*;

  localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CB = $clog2(MAX_WIDTH);
  localparam int unsigned RB = $clog2(MAX_HEIGHT);
  localparam int unsigned EW_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int unsigned EH_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  function automatic logic [7:0] scale_byte(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * a;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // configuration (held as effective values)
  logic [WB-1:0] ew_r;
  logic [HB-1:0] eh_r;
  logic          outl_en_r;

  // stream position
  logic [CB-1:0] in_col_r, out_col_r;
  logic [RB-1:0] in_row_r, out_row_r;
  logic          frame_done_r;
  logic [WB-1:0] cnt_r, cnt_nxt;
  logic          prev_black_r;

  logic [PIX_W-1:0] cell_pix  [MAX_WIDTH];
  logic             cell_flag [MAX_WIDTH];
  cell_ctrl_t       cell_ctrl [MAX_WIDTH];

  logic          acc, pix_acc, pix_emit, drn_emit, emit, cfg_hit, restart;
  logic          last, at_row_end, at_col_end;
  logic [WB-1:0] load_pos;
  logic [PIX_W-1:0] cur, outl_pix;
  logic          cur_black, up_ok, left_ok, right_ok, down_ok;
  res_t          res;

  always_comb begin
    acc      = in_valid && !in_stall;
    pix_acc  = acc && (in_req_type == REQ_PIXEL) && !frame_done_r;
    pix_emit = pix_acc && (cnt_r == ew_r);
    drn_emit = acc && (in_req_type == REQ_DRAIN) && (cnt_r != '0);
    emit     = pix_emit || drn_emit;
    cfg_hit  = cfg_wr_en && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT) ||
                             (cfg_index == CFG_OUTLINE));

    at_col_end = (WB'(out_col_r) == ew_r - WB'(1));
    at_row_end = (HB'(out_row_r) == eh_r - HB'(1));
    last       = at_col_end && at_row_end;
    restart    = cfg_hit || (emit && last);

    cur       = cell_pix[0];
    cur_black = (cur == OPAQUE_BLACK);
    up_ok     = (out_row_r != '0) && cell_flag[0];
    left_ok   = (out_col_r != '0) && prev_black_r;
    right_ok  = (WB'(out_col_r) + WB'(1) < ew_r) && (pix_emit || (cnt_r > WB'(1))) &&
                (cell_pix[1] == OPAQUE_BLACK);
    down_ok   = pix_emit && (HB'(out_row_r) + HB'(1) < eh_r) && (in_pixel_in == OPAQUE_BLACK);

    if (outl_en_r && (cur == '0) && (up_ok || left_ok || right_ok || down_ok)) begin
      outl_pix = OPAQUE_WHITE;
    end else begin
      outl_pix = cur;
    end

    res.pixel = {outl_pix[31:24],
                 scale_byte(outl_pix[23:16], outl_pix[31:24]),
                 scale_byte(outl_pix[15:8],  outl_pix[31:24]),
                 scale_byte(outl_pix[7:0],   outl_pix[31:24])};
    res.last  = last;

    load_pos = emit ? (cnt_r - WB'(1)) : cnt_r;

    if (restart) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + WB'(pix_acc) - WB'(emit);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r      <= WB'(EW_RST);
      eh_r      <= HB'(EH_RST);
      outl_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          if (cfg_wdata[6:0] == '0) begin
            ew_r <= WB'(1);
          end else if (int'(cfg_wdata[6:0]) > int'(MAX_WIDTH)) begin
            ew_r <= WB'(MAX_WIDTH);
          end else begin
            ew_r <= WB'(cfg_wdata[6:0]);
          end
        end
        CFG_HEIGHT: begin
          if (cfg_wdata == '0) begin
            eh_r <= HB'(1);
          end else if (int'(cfg_wdata) > int'(MAX_HEIGHT)) begin
            eh_r <= HB'(MAX_HEIGHT);
          end else begin
            eh_r <= HB'(cfg_wdata);
          end
        end
        CFG_OUTLINE: outl_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stream counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      frame_done_r <= 1'b0;
      cnt_r        <= '0;
      prev_black_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (restart) begin
        in_col_r     <= '0;
        in_row_r     <= '0;
        out_col_r    <= '0;
        out_row_r    <= '0;
        frame_done_r <= 1'b0;
      end else begin
        if (pix_acc) begin
          if (WB'(in_col_r) == ew_r - WB'(1)) begin
            in_col_r <= '0;
            if (HB'(in_row_r) == eh_r - HB'(1)) begin
              in_row_r     <= '0;
              frame_done_r <= 1'b1;
            end else begin
              in_row_r <= in_row_r + RB'(1);
            end
          end else begin
            in_col_r <= in_col_r + CB'(1);
          end
        end
        if (emit) begin
          prev_black_r <= cur_black;
          if (at_col_end) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RB'(1);
          end else begin
            out_col_r <= out_col_r + CB'(1);
          end
        end
      end
    end
  end

  // cell chain: cell 0 holds the oldest pending pixel and the flag for out_col
  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    logic [PIX_W-1:0] nbr_pix;
    logic             nbr_flag;

    if (k == MAX_WIDTH - 1) begin : g_end
      assign nbr_pix  = '0;
      assign nbr_flag = 1'b0;
    end else begin : g_mid
      assign nbr_pix  = cell_pix[k+1];
      assign nbr_flag = cell_flag[k+1];
    end

    always_comb begin
      cell_ctrl[k].clear = restart;
      cell_ctrl[k].shift = emit;
      cell_ctrl[k].load  = pix_acc && (load_pos == WB'(k));
      cell_ctrl[k].tail  = (WB'(k) == ew_r - WB'(1));
    end

    copm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl[k]),
      .in_pix   (in_pixel_in),
      .new_flag (cur_black),
      .nbr_pix  (nbr_pix),
      .nbr_flag (nbr_flag),
      .pix      (cell_pix[k]),
      .flag     (cell_flag[k])
    );
  end

  copm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (emit),
    .res       (res),
    .up_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel_out),
    .out_last  (out_last_pixel)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ew_r)
    else $error("pending pixel count exceeds image width");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done_r |-> (cnt_r != '0) && (in_col_r == '0) && (in_row_r == '0))
    else $error("frame received but nothing pending");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (cnt_r == '0) && !frame_done_r && (out_col_r == '0))
    else $error("stream not restarted after last pixel");

  a_out_col: assert property (@(posedge clk) disable iff (!rst_n)
    WB'(out_col_r) < ew_r)
    else $error("output column out of range");

endmodule

// ===== tb/cursor_outline_premultiply_test.sv =====
// Self-checking bench for cursor_outline_premultiply: outline and premultiply of raster pixels.
// Runs a directed table, a back-pressure image, then random images under several register settings.
// Depends on copm_pkg and the cursor_outline_premultiply RTL.
module cursor_outline_premultiply_test;
  import copm_pkg::*;

  localparam int unsigned MAX_W         = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H         = DEF_MAX_HEIGHT;
  localparam int unsigned WINDOW        = 2 * MAX_W;
  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 50;
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [PIX_W-1:0]    in_pixel_in;
  logic                out_valid;
  logic                out_stall;
  logic [PIX_W-1:0]    out_pixel_out;
  logic                out_last_pixel;

  cursor_outline_premultiply i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  logic [PIX_W-1:0] pix_window [WINDOW];
  bit               above_black [MAX_W];
  int unsigned      fill_row, fill_col, drain_row, drain_col;
  bit               image_full;
  logic [6:0]       reg_width;
  logic [10:0]      reg_height;
  logic             reg_outline;

  res_t             pending_pixels [$];
  res_t             want;
  int unsigned      mismatches, checked, beats, useful_beats, reg_writes, phases;
  int unsigned      quiet_cycles;
  bit               sender_idle, receiver_idle, hold_request;
  int unsigned      stall_left, hold_left;

  function automatic int unsigned act_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_W) return MAX_W;
    return reg_width;
  endfunction

  function automatic int unsigned act_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_H) return MAX_H;
    return reg_height;
  endfunction

  function automatic void restart_image();
    for (int i = 0; i < WINDOW; i++) pix_window[i] = '0;
    for (int i = 0; i < MAX_W; i++) above_black[i] = 1'b0;
    fill_row = 0; fill_col = 0; drain_row = 0; drain_col = 0;
    image_full = 1'b0;
  endfunction

  function automatic int unsigned received_count();
    if (image_full) return act_width() * act_height();
    return fill_row * act_width() + fill_col;
  endfunction

  function automatic logic [PIX_W-1:0] premultiplied(input logic [PIX_W-1:0] px);
    logic [15:0] b, g, r;
    b = 16'(px[23:16]) * 16'(px[31:24]) / 16'd255;
    g = 16'(px[15:8])  * 16'(px[31:24]) / 16'd255;
    r = 16'(px[7:0])   * 16'(px[31:24]) / 16'd255;
    return {px[31:24], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic res_t release_pixel();
    int unsigned      w, h, p, q, c;
    logic [PIX_W-1:0] cur;
    bit               cur_black, up, left, right, down;
    res_t             r;
    w = act_width();
    h = act_height();
    p = drain_row * w + drain_col;
    q = received_count();
    cur = pix_window[p % WINDOW];
    c = drain_col % MAX_W;
    cur_black = (cur == OPAQUE_BLACK);
    if (reg_outline && cur == '0) begin
      up    = drain_row > 0 && above_black[c];
      left  = drain_col > 0 && pix_window[(p - 1) % WINDOW] == OPAQUE_BLACK;
      right = drain_col + 1 < w && p + 1 < q && pix_window[(p + 1) % WINDOW] == OPAQUE_BLACK;
      down  = drain_row + 1 < h && p + w < q && pix_window[(p + w) % WINDOW] == OPAQUE_BLACK;
      if (up || left || right || down) cur = OPAQUE_WHITE;
    end
    above_black[c] = cur_black;
    r.pixel = premultiplied(cur);
    r.last  = (p + 1 == w * h);
    if (r.last) begin
      restart_image();
    end else begin
      drain_col++;
      if (drain_col >= w) begin
        drain_col = 0;
        drain_row++;
      end
    end
    return r;
  endfunction

  // returns 1 when the beat releases a pixel; used is 0 for beats the block drops
  function automatic bit predict_beat(input logic req, input logic [PIX_W-1:0] pix,
                                      output res_t r, output bit used);
    int unsigned w, h, p, q;
    used = 1'b0;
    r = '0;
    w = act_width();
    h = act_height();
    p = drain_row * w + drain_col;
    if (req == REQ_PIXEL) begin
      if (image_full) return 1'b0;
      q = fill_row * w + fill_col;
      pix_window[q % WINDOW] = pix;
      used = 1'b1;
      fill_col++;
      if (fill_col >= w) begin
        fill_col = 0;
        fill_row++;
        if (fill_row >= h) begin
          fill_row = 0;
          image_full = 1'b1;
        end
      end
      if (q + 1 - p > w) begin
        r = release_pixel();
        return 1'b1;
      end
      return 1'b0;
    end
    if (received_count() > p) begin
      r = release_pixel();
      used = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    case (idx)
      CFG_WIDTH:   reg_width = val[6:0];
      CFG_HEIGHT:  reg_height = val;
      CFG_OUTLINE: reg_outline = val[0];
      default:     return;
    endcase
    restart_image();
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("pixel %08h last %0b with nothing expected",
                                out_pixel_out, out_last_pixel));
      end else begin
        want = pending_pixels.pop_front();
        checked++;
        if (out_pixel_out !== want.pixel)
          flag_mismatch($sformatf("pixel_out %08h, expected %08h", out_pixel_out, want.pixel));
        if (out_last_pixel !== want.last)
          flag_mismatch($sformatf("last_pixel %0b, expected %0b on pixel %08h",
                                  out_last_pixel, want.last, want.pixel));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
      end else if (out_valid) begin
        stall_left = receiver_idle ? $urandom_range(0, 10) : 0;
        if (stall_left != 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_beat(input logic req, input logic [PIX_W-1:0] pix,
                           input bit typed, input res_t typed_res);
    int unsigned gap;
    res_t        r;
    bit          has, used;
    gap = sender_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_pixel_in <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = predict_beat(req, pix, r, used);
    if (typed) begin
      has = 1'b1;
      r = typed_res;
    end
    if (has) pending_pixels.push_back(r);
    if (used) useful_beats++;
    beats++;
  endtask

  // only while idle: all results in, then a short pause for the block to settle
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_wr_en <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3, 4, 5: return OPAQUE_BLACK;
      6:       return OPAQUE_WHITE;
      7:       return {8'($urandom_range(0, 255)), 24'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // npix pixels with the odd early drain, a little noise, then a flush
  task automatic send_image(input int unsigned npix, input int unsigned w);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 24) == 0) send_beat(REQ_DRAIN, $urandom(), 1'b0, '0);
      send_beat(REQ_PIXEL, random_pixel(), 1'b0, '0);
    end
    repeat ($urandom_range(0, 2)) send_beat(REQ_PIXEL, random_pixel(), 1'b0, '0);
    repeat (w + 1 + $urandom_range(0, 2)) send_beat(REQ_DRAIN, $urandom(), 1'b0, '0);
  endtask

  task automatic run_phase();
    logic [6:0]  w;
    logic [10:0] h;
    int unsigned aw, ah, npix;
    case ($urandom_range(0, 19))
      0:       w = 7'd0;
      1:       w = 7'd1;
      2:       w = 7'd64;
      3:       w = 7'($urandom_range(65, 127));
      default: w = 7'($urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 15))
      0:       h = 11'd0;
      1:       h = 11'd1;
      2:       h = 11'($urandom_range(1025, 2047));
      3:       h = 11'd1024;
      default: h = 11'($urandom_range(2, 8));
    endcase
    write_reg(CFG_WIDTH, {4'($urandom_range(0, 15)), w});
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_OUTLINE, {10'($urandom()), 1'($urandom_range(0, 1))});
    sender_idle   = $urandom_range(0, 3) != 0;
    receiver_idle = $urandom_range(0, 3) != 0;
    aw = act_width();
    ah = act_height();
    if (aw * ah > 256) begin
      npix = aw * $urandom_range(1, 3) + $urandom_range(0, aw - 1);
      send_image(npix, aw);
    end else begin
      repeat ($urandom_range(1, 2)) send_image(aw * ah, aw);
    end
    phases++;
  endtask

  // ---------------------------------------------------------------- directed
  typedef struct packed {
    logic              is_reg;
    logic [CFG_IW-1:0] idx;
    logic [CFG_DW-1:0] val;
    logic              req;
    logic [PIX_W-1:0]  pix;
    logic              typed;
    res_t              exp;
  } dir_row_t;

  localparam int DIR_ROWS = 36;
  dir_row_t dir_table [DIR_ROWS] = '{
    // reset settings, 32x32: lone transparent pixel, no neighbor yet
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    // 1x1 images
    '{1'b1, CFG_WIDTH,   11'd1,  '0,        '0,            1'b0, '0},
    '{1'b1, CFG_HEIGHT,  11'd1,  '0,        '0,            1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, OPAQUE_BLACK,  1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'hffff_ffff, 1'b1, '{OPAQUE_BLACK, 1'b1}},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, OPAQUE_WHITE,  1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b1, '{OPAQUE_WHITE, 1'b1}},
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h80ff_8040, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b1, '{32'h8080_4020, 1'b1}},
    // zero sizes act as 1
    '{1'b1, CFG_WIDTH,   11'd0,  '0,        '0,            1'b0, '0},
    '{1'b1, CFG_HEIGHT,  11'd0,  '0,        '0,            1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h00ff_ffff, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    // 2x2, outline on: early drain, pixel after full frame, flush
    '{1'b1, CFG_WIDTH,   11'd2,  '0,        '0,            1'b0, '0},
    '{1'b1, CFG_HEIGHT,  11'd2,  '0,        '0,            1'b0, '0},
    '{1'b1, CFG_OUTLINE, 11'd1,  '0,        '0,            1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, OPAQUE_BLACK,  1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, OPAQUE_BLACK,  1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h1234_5678, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b0, '0},
    // outline off; unused index must not restart the stream
    '{1'b1, CFG_OUTLINE, 11'd0,  '0,        '0,            1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, 32'h0000_0000, 1'b0, '0},
    '{1'b1, CFG_SPARE,   11'h7ff, '0,       '0,            1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, OPAQUE_BLACK,  1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b0, '0},
    // oversized registers saturate
    '{1'b1, CFG_WIDTH,   11'h7ff, '0,       '0,            1'b0, '0},
    '{1'b1, CFG_HEIGHT,  11'h7ff, '0,       '0,            1'b0, '0},
    '{1'b0, '0,          '0,     REQ_PIXEL, OPAQUE_WHITE,  1'b0, '0},
    '{1'b0, '0,          '0,     REQ_DRAIN, 32'h0000_0000, 1'b1, '{OPAQUE_WHITE, 1'b0}}
  };

  // ---------------------------------------------------------------- main
  initial begin
    int unsigned start;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_req_type   = REQ_PIXEL;
    in_pixel_in   = '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_request  = 1'b0;
    mismatches = 0; checked = 0; beats = 0; useful_beats = 0; reg_writes = 0; phases = 0;
    quiet_cycles  = 0;
    reg_width     = 7'(WIDTH_RST);
    reg_height    = 11'(HEIGHT_RST);
    reg_outline   = 1'b1;
    restart_image();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].is_reg)
        write_reg(dir_table[i].idx, dir_table[i].val);
      else
        send_beat(dir_table[i].req, dir_table[i].pix, dir_table[i].typed, dir_table[i].exp);
    end

    // back-pressure: long receiver hold while the sender keeps going
    write_reg(CFG_WIDTH, 11'd8);
    write_reg(CFG_HEIGHT, 11'd8);
    write_reg(CFG_OUTLINE, 11'd1);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_request  = 1'b1;
    send_image(64, 8);

    start = useful_beats;
    while (useful_beats - start < RANDOM_ITEMS) run_phase();

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d beats (%0d effective), %0d result pixels checked, %0d register writes",
             beats, useful_beats, checked, reg_writes);
    $display("%0d random image settings after the directed table and one back-pressure image",
             phases);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
